// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the display scan block, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/msds_pkg.sv =====
// ---------------------------------------------------------------------------
// msds_pkg
// Types and constants of the multiplexed segment display scanner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msds_pkg;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_TEAM_A = 2'd2,
		OP_TEAM_B = 2'd3
	} op_t;

	localparam logic [2:0] REG_ALLOW      = 3'd0;
	localparam logic [2:0] REG_FAST_BLINK = 3'd1;
	localparam logic [2:0] REG_SLOW_BLINK = 3'd2;
	localparam logic [2:0] REG_FAST_HALF  = 3'd3;
	localparam logic [2:0] REG_SLOW_HALF  = 3'd4;

	localparam int ADDR_W = 5;

	localparam logic [15:0] FAST_RESET  = 16'd1667;
	localparam logic [15:0] SLOW_RESET  = 16'd5000;
	localparam logic [7:0]  TEAM_A_MASK = 8'hF0;
	localparam logic [7:0]  TEAM_B_MASK = 8'h0F;

	localparam int IN_W = 16;

	typedef struct packed {
		logic        allow_output;
		logic [15:0] fast_half_period;
		logic [15:0] slow_half_period;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/msds_cfg.sv =====
// ---------------------------------------------------------------------------
// msds_cfg
// APB register file: output enable, blink masks and blink half periods.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msds_cfg
	import msds_pkg::*;
#(
	parameter int POSITIONS = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output cfg_t                      cfg,
	output logic      [POSITIONS-1:0] fast_blink,
	output logic      [POSITIONS-1:0] slow_blink
);

	logic                 allow_q;
	logic [POSITIONS-1:0] fast_blink_q;
	logic [POSITIONS-1:0] slow_blink_q;
	logic [15:0]          fast_half_q;
	logic [15:0]          slow_half_q;
	logic [2:0]           index;
	logic                 wr_en;

	assign pready = 1'b1;
	assign index  = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q      <= 1'b0;
			fast_blink_q <= '0;
			slow_blink_q <= '0;
			fast_half_q  <= FAST_RESET;
			slow_half_q  <= SLOW_RESET;
		end else if (wr_en) begin
			case (index)
				REG_ALLOW:      allow_q      <= pwdata[0];
				REG_FAST_BLINK: fast_blink_q <= pwdata[POSITIONS-1:0];
				REG_SLOW_BLINK: slow_blink_q <= pwdata[POSITIONS-1:0];
				REG_FAST_HALF:  fast_half_q  <= pwdata[15:0];
				REG_SLOW_HALF:  slow_half_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_ALLOW:      prdata = {31'd0, allow_q};
			REG_FAST_BLINK: prdata = 32'(fast_blink_q);
			REG_SLOW_BLINK: prdata = 32'(slow_blink_q);
			REG_FAST_HALF:  prdata = {16'd0, fast_half_q};
			REG_SLOW_HALF:  prdata = {16'd0, slow_half_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.allow_output     = allow_q;
	assign cfg.fast_half_period = fast_half_q;
	assign cfg.slow_half_period = slow_half_q;
	assign fast_blink           = fast_blink_q;
	assign slow_blink           = slow_blink_q;

endmodule

`default_nettype wire

// ===== rtl/msds_core.sv =====
// ---------------------------------------------------------------------------
// msds_core
// Pattern store, blink counters and scan select, with the tick result logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msds_core
	import msds_pkg::*;
#(
	parameter int POSITIONS = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic [POSITIONS-1:0] fast_blink,
	input  wire logic [POSITIONS-1:0] slow_blink,
	input  wire logic                 fire,
	input  wire op_t                  op,
	input  wire logic [2:0]           position,
	input  wire logic [7:0]           pattern,
	input  wire logic [3:0]           indicator_bits,
	output logic      [POSITIONS-1:0] digit_drive,
	output logic      [7:0]           segment_drive
);

	localparam int ROW = POSITIONS - 1;

	logic [POSITIONS-1:0] select_q;
	logic [POSITIONS-1:0] select_d;
	logic [7:0]           store_q [POSITIONS];
	logic [7:0]           store_d [POSITIONS];
	logic [15:0]          fast_count_q;
	logic [15:0]          slow_count_q;
	logic [15:0]          fast_count_d;
	logic [15:0]          slow_count_d;
	logic [15:0]          fast_dec;
	logic [15:0]          slow_dec;
	logic                 fast_phase_q;
	logic                 slow_phase_q;
	logic                 fast_phase_d;
	logic                 slow_phase_d;
	logic [7:0]           seg_sel;
	logic                 tick;

	assign tick = fire && (op == OP_TICK);

	// blink counters and select rotate
	assign fast_dec = fast_count_q - 16'd1;
	assign slow_dec = slow_count_q - 16'd1;

	always_comb begin
		fast_count_d = fast_dec;
		fast_phase_d = fast_phase_q;
		if (fast_dec == 16'd0) begin
			fast_count_d = cfg.fast_half_period;
			fast_phase_d = !fast_phase_q;
		end
		slow_count_d = slow_dec;
		slow_phase_d = slow_phase_q;
		if (slow_dec == 16'd0) begin
			slow_count_d = cfg.slow_half_period;
			slow_phase_d = !slow_phase_q;
		end
	end

	assign select_d = {select_q[POSITIONS-2:0], select_q[POSITIONS-1]};

	// pattern and indicator writes
	always_comb begin
		for (int i = 0; i < POSITIONS; i++) begin
			store_d[i] = store_q[i];
			if (op == OP_WRITE && 32'(position) == i) begin
				store_d[i] = pattern;
			end
		end
		case (op)
			OP_TEAM_A: store_d[ROW] = ({indicator_bits, 4'd0} & TEAM_A_MASK) |
				(store_q[ROW] & TEAM_B_MASK);
			OP_TEAM_B: store_d[ROW] = ({4'd0, indicator_bits} & TEAM_B_MASK) |
				(store_q[ROW] & TEAM_A_MASK);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q     <= POSITIONS'(1);
			fast_count_q <= FAST_RESET;
			slow_count_q <= SLOW_RESET;
			fast_phase_q <= 1'b0;
			slow_phase_q <= 1'b0;
			for (int i = 0; i < POSITIONS; i++) begin
				store_q[i] <= 8'd0;
			end
		end else if (fire) begin
			if (tick) begin
				select_q     <= select_d;
				fast_count_q <= fast_count_d;
				slow_count_q <= slow_count_d;
				fast_phase_q <= fast_phase_d;
				slow_phase_q <= slow_phase_d;
			end else begin
				for (int i = 0; i < POSITIONS; i++) begin
					store_q[i] <= store_d[i];
				end
			end
		end
	end

	// result of a tick, from the new select and phases
	always_comb begin
		seg_sel = 8'd0;
		for (int i = 0; i < POSITIONS; i++) begin
			if (select_d[i]) begin
				seg_sel = seg_sel | store_q[i];
			end
		end
	end

	always_comb begin
		digit_drive   = select_d;
		segment_drive = seg_sel;
		if ((select_d & fast_blink) != '0 && !fast_phase_d) begin
			digit_drive = '0;
		end
		if ((select_d & slow_blink) != '0 && !slow_phase_d) begin
			digit_drive = '0;
		end
		if (!cfg.allow_output) begin
			digit_drive   = '0;
			segment_drive = 8'd0;
		end
	end

	`ASSERT_ALWAYS(a_select_onehot, clk, arst_n, $onehot(select_q), "scan select not one-hot")
	`ASSERT_ALWAYS(a_digit_masked, clk, arst_n, digit_drive == '0 || digit_drive == select_d,
		"digit enable differs from select")
	`ASSERT_IMPLIES(a_blank_when_off, clk, arst_n, !cfg.allow_output,
		digit_drive == '0 && segment_drive == 8'd0, "output driven while disallowed")
	`ASSERT_NEXT(a_write_keeps_scan, clk, arst_n, fire && op != OP_TICK,
		$stable(select_q) && $stable(fast_count_q), "write item moved scan state")

endmodule

`default_nettype wire

// ===== rtl/multiplexed_segment_display_scan.sv =====
// ---------------------------------------------------------------------------
// multiplexed_segment_display_scan
// Scan driver for multiplexed segment digits with blink masking.
//
// Items arrive on the s_ stream: s_tuser carries the opcode (tick, pattern
// write, team A or team B indicators), s_tdata the operands. A tick yields
// one transfer on the m_ stream with the digit enable and segment pattern of
// the next scan position; write items yield none. Registers sit on the APB
// port; the user must see that they are written only while the stream is
// quiet, as the block does not enforce it. A tick passes the input register
// (s1), the core update and the output register (s2) driving m_tvalid.
// Throughput is one item per cycle unless a tick in the input stage waits
// on a blocked output; the core update is a single pass of counter decrement,
// one-hot rotate and an 8-bit select between the two registers.
// Reset clears the pattern store, selects the first digit, loads the blink
// counters with their reset half periods and clears m_tvalid and the output enable.
// When m_tready is low a finished tick waits in the output register; the
// input register still drains write items and one more tick can be taken
// before s_tready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multiplexed_segment_display_scan
	import msds_pkg::*;
#(
	parameter int POSITIONS = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// position[2:0], pattern[10:3], indicator_bits[14:11]
	input  wire logic [IN_W-1:0]   s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// digit_drive[POSITIONS-1:0], segment_drive[POSITIONS+7:POSITIONS]
	output logic [((POSITIONS+15)/8)*8-1:0] m_tdata
);

	localparam int OUT_W = ((POSITIONS + 15) / 8) * 8;

	cfg_t                 cfg;
	logic [POSITIONS-1:0] fast_blink;
	logic [POSITIONS-1:0] slow_blink;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [2:0]           position_s1;
	logic [7:0]           pattern_s1;
	logic [3:0]           ind_s1;
	logic                 valid_s2;
	logic [POSITIONS-1:0] digit_s2;
	logic [7:0]           seg_s2;
	logic                 advance;
	logic                 fire;
	logic [POSITIONS-1:0] digit_d;
	logic [7:0]           seg_d;

	msds_cfg #(
		.POSITIONS(POSITIONS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.fast_blink (fast_blink),
		.slow_blink (slow_blink)
	);

	// input stage moves unless it holds a tick and the output is blocked
	assign advance  = !valid_s1 || op_s1 != OP_TICK || !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			op_s1       <= op_t'(s_tuser);
			position_s1 <= s_tdata[2:0];
			pattern_s1  <= s_tdata[10:3];
			ind_s1      <= s_tdata[14:11];
		end
	end

	msds_core #(
		.POSITIONS(POSITIONS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.fast_blink     (fast_blink),
		.slow_blink     (slow_blink),
		.fire           (fire),
		.op             (op_s1),
		.position       (position_s1),
		.pattern        (pattern_s1),
		.indicator_bits (ind_s1),
		.digit_drive    (digit_d),
		.segment_drive  (seg_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && op_s1 == OP_TICK) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && op_s1 == OP_TICK) begin
			digit_s2 <= digit_d;
			seg_s2   <= seg_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'({seg_s2, digit_s2});

	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, valid_s2 && !m_tready,
		!(fire && op_s1 == OP_TICK), "pending result overwritten")
	`ASSERT_NEXT(a_write_no_result, clk, arst_n,
		fire && op_s1 != OP_TICK && !valid_s2, !valid_s2, "write item produced a result")

endmodule

`default_nettype wire
